// ----- rtl/i2cm_pkg.sv -----
// Shared codes, widths and beat payload types for the I2C register access master.
package i2cm_pkg;

    // Request codes carried in the kind field
    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_TICK  = 2'd2;

    // Field widths
    localparam int KIND_W = 2;
    localparam int BYTE_W = 8;

    // Read bit set in the device byte of the read phase
    localparam logic [BYTE_W-1:0] RW_READ_BIT = 8'h01;

    // Bits per byte on the bus
    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

    // Byte sequence steps
    localparam logic [2:0] STEP_DEVICE   = 3'd0;
    localparam logic [2:0] STEP_REGISTER = 3'd1;
    localparam logic [2:0] STEP_DATA     = 3'd2;
    localparam logic [2:0] STEP_RD_DEV   = 3'd3;
    localparam logic [2:0] STEP_RD_DATA  = 3'd4;

    // Input beat payload
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] device_address;
        logic [BYTE_W-1:0] register_address;
        logic [BYTE_W-1:0] write_data;
        logic              sda_in;
    } t_in_beat;

    // Result beat payload
    typedef struct packed {
        logic              scl;
        logic              sda_out;
        logic              busy_res;
        logic              done_res;
        logic [BYTE_W-1:0] read_data;
        logic              request_dropped;
    } t_out_beat;

endpackage

// ----- rtl/i2cm_if.sv -----
// Valid/ready channel interfaces for request beats and result beats.
interface i2cm_in_if;
    logic                          valid;
    logic                          ready;
    logic [i2cm_pkg::KIND_W-1:0]   kind;
    logic [i2cm_pkg::BYTE_W-1:0]   device_address;
    logic [i2cm_pkg::BYTE_W-1:0]   register_address;
    logic [i2cm_pkg::BYTE_W-1:0]   write_data;
    logic                          sda_in;

    modport source (output valid, kind, device_address, register_address, write_data,
                    sda_in, input ready);
    modport sink   (input valid, kind, device_address, register_address, write_data,
                    sda_in, output ready);
endinterface

interface i2cm_out_if;
    logic                          valid;
    logic                          ready;
    logic                          scl;
    logic                          sda_out;
    logic                          busy_res;
    logic                          done_res;
    logic [i2cm_pkg::BYTE_W-1:0]   read_data;
    logic                          request_dropped;

    modport source (output valid, scl, sda_out, busy_res, done_res, read_data,
                    request_dropped, input ready);
    modport sink   (input valid, scl, sda_out, busy_res, done_res, read_data,
                    request_dropped, output ready);
endinterface

// ----- rtl/i2c_register_access_master_core.sv -----
// Top level: I2C master sequencer for single register writes and reads.
// Each request beat on i_in yields exactly one result beat on o_res, registered when it is
// accepted; a new beat is taken every cycle as long as the result register is empty or is
// being drained in the same cycle, so the sustained rate is one beat per cycle, set by the
// single registered state update of the bus sequencer. A write or read request is latched
// when the sequencer is idle and flagged as dropped otherwise. Each tick beat advances the
// bus by one half-period and reports the SCL and SDA levels driven for it: a write takes
// 58 ticks (START, device, register, data, STOP) and a read takes 80 (START, device,
// register, STOP, START, device with read bit, eight sampled bits, NACK, STOP). The
// acknowledge bit is released and not checked.
module i2c_register_access_master_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    i2cm_in_if.sink     i_in,
    i2cm_out_if.source  o_res
);

    typedef enum logic [3:0] {
        PH_IDLE   = 4'd0,
        PH_STA_A  = 4'd1,
        PH_STA_B  = 4'd2,
        PH_SND_HI = 4'd3,
        PH_SND_LO = 4'd4,
        PH_ACK_HI = 4'd5,
        PH_ACK_LO = 4'd6,
        PH_STO_A  = 4'd7,
        PH_STO_B  = 4'd8,
        PH_RCV_HI = 4'd9,
        PH_RCV_LO = 4'd10,
        PH_NAK_HI = 4'd11,
        PH_NAK_LO = 4'd12
    } t_phase;

    // Sequencer state
    t_phase                        r_phase,    n_phase;
    logic [3:0]                    r_bit_cnt,  n_bit_cnt;
    logic [2:0]                    r_step,     n_step;
    logic [i2cm_pkg::BYTE_W-1:0]   r_shift,    n_shift;
    logic [i2cm_pkg::BYTE_W-1:0]   r_captured, n_captured;
    logic                          r_is_read,  n_is_read;
    logic [i2cm_pkg::BYTE_W-1:0]   r_dev,      n_dev;
    logic [i2cm_pkg::BYTE_W-1:0]   r_reg,      n_reg;
    logic [i2cm_pkg::BYTE_W-1:0]   r_data,     n_data;
    logic                          r_scl,      n_scl;
    logic                          r_sda,      n_sda;

    // Result register
    logic                          r_out_valid;
    i2cm_pkg::t_out_beat           r_out,      n_out;

    logic                          in_accept;
    logic                          n_done;
    logic                          n_dropped;
    logic [3:0]                    bit_cnt_inc;
    logic [i2cm_pkg::BYTE_W-1:0]   step_byte;

    assign i_in.ready = !r_out_valid || o_res.ready;
    assign in_accept  = i_in.valid && i_in.ready;
    assign bit_cnt_inc = r_bit_cnt + 4'd1;

    // Byte to load when a send begins at the current step
    always_comb begin
        case (r_step)
            i2cm_pkg::STEP_DEVICE:   step_byte = r_dev;
            i2cm_pkg::STEP_REGISTER: step_byte = r_reg;
            i2cm_pkg::STEP_DATA:     step_byte = r_data;
            default:                 step_byte = r_dev | i2cm_pkg::RW_READ_BIT;
        endcase
    end

    // Next state for one accepted beat
    always_comb begin
        n_phase    = r_phase;
        n_bit_cnt  = r_bit_cnt;
        n_step     = r_step;
        n_shift    = r_shift;
        n_captured = r_captured;
        n_is_read  = r_is_read;
        n_dev      = r_dev;
        n_reg      = r_reg;
        n_data     = r_data;
        n_scl      = r_scl;
        n_sda      = r_sda;
        n_done     = 1'b0;
        n_dropped  = 1'b0;

        if (i_in.kind == i2cm_pkg::KIND_WRITE || i_in.kind == i2cm_pkg::KIND_READ) begin
            if (r_phase != PH_IDLE) begin
                n_dropped = 1'b1;
            end else begin
                n_dev     = i_in.device_address;
                n_reg     = i_in.register_address;
                n_data    = i_in.write_data;
                n_is_read = (i_in.kind == i2cm_pkg::KIND_READ);
                n_step    = i2cm_pkg::STEP_DEVICE;
                n_bit_cnt = 4'd0;
                n_phase   = PH_STA_A;
            end
        end else if (i_in.kind == i2cm_pkg::KIND_TICK) begin
            case (r_phase)
                PH_STA_A: begin
                    n_scl = 1'b1; n_sda = 1'b1;
                    n_phase = PH_STA_B;
                end
                PH_STA_B: begin
                    n_scl = 1'b1; n_sda = 1'b0;
                    n_shift = step_byte;
                    n_bit_cnt = 4'd0;
                    n_phase = PH_SND_HI;
                end
                PH_SND_HI: begin
                    n_scl = 1'b1; n_sda = r_shift[i2cm_pkg::BYTE_W-1];
                    n_phase = PH_SND_LO;
                end
                PH_SND_LO: begin
                    n_scl = 1'b0; n_sda = r_shift[i2cm_pkg::BYTE_W-1];
                    n_shift = {r_shift[i2cm_pkg::BYTE_W-2:0], 1'b0};
                    n_bit_cnt = bit_cnt_inc;
                    n_phase = (bit_cnt_inc >= i2cm_pkg::BITS_PER_BYTE) ? PH_ACK_HI : PH_SND_HI;
                end
                PH_ACK_HI: begin
                    // acknowledge slot: line released, response not checked
                    n_scl = 1'b1; n_sda = 1'b1;
                    n_phase = PH_ACK_LO;
                end
                PH_ACK_LO: begin
                    n_scl = 1'b0; n_sda = 1'b1;
                    if (r_step == i2cm_pkg::STEP_DEVICE) begin
                        n_step = i2cm_pkg::STEP_REGISTER;
                        n_shift = r_reg;
                        n_bit_cnt = 4'd0;
                        n_phase = PH_SND_HI;
                    end else if (r_step == i2cm_pkg::STEP_REGISTER) begin
                        if (r_is_read) begin
                            n_phase = PH_STO_A;
                        end else begin
                            n_step = i2cm_pkg::STEP_DATA;
                            n_shift = r_data;
                            n_bit_cnt = 4'd0;
                            n_phase = PH_SND_HI;
                        end
                    end else if (r_step == i2cm_pkg::STEP_RD_DEV) begin
                        n_step = i2cm_pkg::STEP_RD_DATA;
                        n_shift = '0;
                        n_bit_cnt = 4'd0;
                        n_phase = PH_RCV_HI;
                    end else begin
                        n_phase = PH_STO_A;
                    end
                end
                PH_STO_A: begin
                    n_scl = 1'b1; n_sda = 1'b0;
                    n_phase = PH_STO_B;
                end
                PH_STO_B: begin
                    n_scl = 1'b1; n_sda = 1'b1;
                    // stop, then a new start into the read phase after the register byte
                    if (r_is_read && r_step == i2cm_pkg::STEP_REGISTER) begin
                        n_step = i2cm_pkg::STEP_RD_DEV;
                        n_phase = PH_STA_A;
                    end else begin
                        n_phase = PH_IDLE;
                        n_done = 1'b1;
                    end
                end
                PH_RCV_HI: begin
                    n_scl = 1'b1; n_sda = 1'b1;
                    n_shift = {r_shift[i2cm_pkg::BYTE_W-2:0], i_in.sda_in};
                    n_phase = PH_RCV_LO;
                end
                PH_RCV_LO: begin
                    n_scl = 1'b0; n_sda = 1'b1;
                    n_bit_cnt = bit_cnt_inc;
                    if (bit_cnt_inc >= i2cm_pkg::BITS_PER_BYTE) begin
                        n_captured = r_shift;
                        n_phase = PH_NAK_HI;
                    end else begin
                        n_phase = PH_RCV_HI;
                    end
                end
                PH_NAK_HI: begin
                    n_scl = 1'b1; n_sda = 1'b1;
                    n_phase = PH_NAK_LO;
                end
                PH_NAK_LO: begin
                    n_scl = 1'b0; n_sda = 1'b1;
                    n_phase = PH_STO_A;
                end
                default: begin
                    // idle or unused code: lines released, sequencer parked
                    n_scl = 1'b1; n_sda = 1'b1;
                    n_phase = PH_IDLE;
                end
            endcase
        end

        n_out.scl             = n_scl;
        n_out.sda_out         = n_sda;
        n_out.busy_res        = (n_phase != PH_IDLE);
        n_out.done_res        = n_done;
        n_out.read_data       = n_captured;
        n_out.request_dropped = n_dropped;
    end

    // State and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_bit_cnt   <= 4'd0;
            r_step      <= i2cm_pkg::STEP_DEVICE;
            r_shift     <= '0;
            r_captured  <= '0;
            r_is_read   <= 1'b0;
            r_dev       <= '0;
            r_reg       <= '0;
            r_data      <= '0;
            r_scl       <= 1'b1;
            r_sda       <= 1'b1;
            r_out_valid <= 1'b0;
            r_out       <= '0;
        end else begin
            if (in_accept) begin
                r_phase     <= n_phase;
                r_bit_cnt   <= n_bit_cnt;
                r_step      <= n_step;
                r_shift     <= n_shift;
                r_captured  <= n_captured;
                r_is_read   <= n_is_read;
                r_dev       <= n_dev;
                r_reg       <= n_reg;
                r_data      <= n_data;
                r_scl       <= n_scl;
                r_sda       <= n_sda;
                r_out_valid <= 1'b1;
                r_out       <= n_out;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_res.valid           = r_out_valid;
    assign o_res.scl             = r_out.scl;
    assign o_res.sda_out         = r_out.sda_out;
    assign o_res.busy_res        = r_out.busy_res;
    assign o_res.done_res        = r_out.done_res;
    assign o_res.read_data       = r_out.read_data;
    assign o_res.request_dropped = r_out.request_dropped;

    // Idle bus leaves both lines released
    a_idle_released: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_IDLE) |-> (r_scl && r_sda))
        else $error("idle sequencer with a line pulled low");

    // Bit counter never passes one byte
    a_bit_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bit_cnt <= i2cm_pkg::BITS_PER_BYTE)
        else $error("bit counter overran a byte");

    // A finished transaction reports not busy
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.done_res) |-> !r_out.busy_res)
        else $error("done reported while still busy");

    // A dropped request was seen while a transaction ran
    a_drop_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && n_dropped) |=> (r_phase != PH_IDLE) && r_out.busy_res)
        else $error("request dropped with sequencer idle");

endmodule

// ----- test/i2c_register_access_master_core_tb.sv -----
// Testbench for the I2C register access master: directed script plus random transactions.
`timescale 1ns / 1ps

module i2c_register_access_master_core_tb;

    // Unused kind code: the block does nothing with it
    localparam logic [1:0] KIND_NONE = 2'd3;
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned RANDOM_ITEMS = 300;
    localparam int unsigned WRITE_TICKS = 58;
    localparam int unsigned READ_TICKS = 80;

    // Bus sequencer phases of the predictor
    typedef enum logic [4:0] {
        PH_IDLE, PH_STA_A, PH_STA_B, PH_SND_HI, PH_SND_LO, PH_ACK_HI, PH_ACK_LO,
        PH_STO_A, PH_STO_B, PH_RCV_HI, PH_RCV_LO, PH_NAK_HI, PH_NAK_LO
    } t_bus_phase;

    // One line of the directed script
    typedef struct {
        i2cm_pkg::t_in_beat    beat;
        int unsigned           reps;
        bit                    typed;
        i2cm_pkg::t_out_beat   res;
    } t_script_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    i2cm_in_if  in_ch();
    i2cm_out_if res_ch();

    i2c_register_access_master_core u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_res   (res_ch)
    );

    always #2 i_clk = ~i_clk;

    // Predictor state, reset values
    t_bus_phase  seq_phase = PH_IDLE;
    logic [3:0]  bits_done = '0;
    logic [2:0]  byte_idx  = i2cm_pkg::STEP_DEVICE;
    logic [7:0]  tx_shift  = '0;
    logic [7:0]  rx_byte   = '0;
    logic        op_is_read = 1'b0;
    logic [7:0]  lat_dev   = '0;
    logic [7:0]  lat_reg   = '0;
    logic [7:0]  lat_data  = '0;
    logic        scl_lvl   = 1'b1;
    logic        sda_lvl   = 1'b1;

    i2cm_pkg::t_out_beat pending_res[$];
    t_script_row script[$];
    int unsigned fails = 0;
    int unsigned cycles = 0;
    bit          calm = 1'b0;

    // Load the next byte to shift out and start its first bit
    function automatic void load_byte(logic [2:0] step);
        byte_idx = step;
        case (step)
            i2cm_pkg::STEP_DEVICE:   tx_shift = lat_dev;
            i2cm_pkg::STEP_REGISTER: tx_shift = lat_reg;
            i2cm_pkg::STEP_DATA:     tx_shift = lat_data;
            default:                 tx_shift = lat_dev | i2cm_pkg::RW_READ_BIT;
        endcase
        bits_done = '0;
        seq_phase = PH_SND_HI;
    endfunction

    // Advance the predicted bus by one accepted beat and return the line levels
    function automatic i2cm_pkg::t_out_beat bus_half_step(i2cm_pkg::t_in_beat b);
        i2cm_pkg::t_out_beat r;
        logic      done;
        logic      dropped;
        done = 1'b0;
        dropped = 1'b0;
        if (b.kind == i2cm_pkg::KIND_WRITE || b.kind == i2cm_pkg::KIND_READ) begin
            if (seq_phase != PH_IDLE) begin
                dropped = 1'b1;
            end else begin
                lat_dev    = b.device_address;
                lat_reg    = b.register_address;
                lat_data   = b.write_data;
                op_is_read = (b.kind == i2cm_pkg::KIND_READ);
                byte_idx   = i2cm_pkg::STEP_DEVICE;
                bits_done  = '0;
                seq_phase  = PH_STA_A;
            end
        end else if (b.kind == i2cm_pkg::KIND_TICK) begin
            case (seq_phase)
                PH_STA_A: begin
                    scl_lvl = 1'b1; sda_lvl = 1'b1;
                    seq_phase = PH_STA_B;
                end
                PH_STA_B: begin
                    scl_lvl = 1'b1; sda_lvl = 1'b0;
                    load_byte(byte_idx);
                end
                PH_SND_HI: begin
                    scl_lvl = 1'b1; sda_lvl = tx_shift[7];
                    seq_phase = PH_SND_LO;
                end
                PH_SND_LO: begin
                    scl_lvl = 1'b0; sda_lvl = tx_shift[7];
                    tx_shift = tx_shift << 1;
                    bits_done = bits_done + 4'd1;
                    seq_phase = (bits_done >= i2cm_pkg::BITS_PER_BYTE) ? PH_ACK_HI : PH_SND_HI;
                end
                PH_ACK_HI: begin
                    // ack bit released; its level does not matter
                    scl_lvl = 1'b1; sda_lvl = 1'b1;
                    seq_phase = PH_ACK_LO;
                end
                PH_ACK_LO: begin
                    scl_lvl = 1'b0; sda_lvl = 1'b1;
                    if (byte_idx == i2cm_pkg::STEP_DEVICE) begin
                        load_byte(i2cm_pkg::STEP_REGISTER);
                    end else if (byte_idx == i2cm_pkg::STEP_REGISTER) begin
                        if (op_is_read) seq_phase = PH_STO_A;
                        else load_byte(i2cm_pkg::STEP_DATA);
                    end else if (byte_idx == i2cm_pkg::STEP_RD_DEV) begin
                        byte_idx = i2cm_pkg::STEP_RD_DATA;
                        tx_shift = '0;
                        bits_done = '0;
                        seq_phase = PH_RCV_HI;
                    end else begin
                        seq_phase = PH_STO_A;
                    end
                end
                PH_STO_A: begin
                    scl_lvl = 1'b1; sda_lvl = 1'b0;
                    seq_phase = PH_STO_B;
                end
                PH_STO_B: begin
                    scl_lvl = 1'b1; sda_lvl = 1'b1;
                    // a read restarts after the register byte
                    if (op_is_read && byte_idx == i2cm_pkg::STEP_REGISTER) begin
                        byte_idx = i2cm_pkg::STEP_RD_DEV;
                        seq_phase = PH_STA_A;
                    end else begin
                        seq_phase = PH_IDLE;
                        done = 1'b1;
                    end
                end
                PH_RCV_HI: begin
                    scl_lvl = 1'b1; sda_lvl = 1'b1;
                    tx_shift = {tx_shift[6:0], b.sda_in};
                    seq_phase = PH_RCV_LO;
                end
                PH_RCV_LO: begin
                    scl_lvl = 1'b0; sda_lvl = 1'b1;
                    bits_done = bits_done + 4'd1;
                    if (bits_done >= i2cm_pkg::BITS_PER_BYTE) begin
                        rx_byte = tx_shift;
                        seq_phase = PH_NAK_HI;
                    end else begin
                        seq_phase = PH_RCV_HI;
                    end
                end
                PH_NAK_HI: begin
                    scl_lvl = 1'b1; sda_lvl = 1'b1;
                    seq_phase = PH_NAK_LO;
                end
                PH_NAK_LO: begin
                    scl_lvl = 1'b0; sda_lvl = 1'b1;
                    seq_phase = PH_STO_A;
                end
                default: begin
                    // idle tick: lines stay released
                    scl_lvl = 1'b1; sda_lvl = 1'b1;
                    seq_phase = PH_IDLE;
                end
            endcase
        end
        r.scl = scl_lvl;
        r.sda_out = sda_lvl;
        r.busy_res = (seq_phase != PH_IDLE);
        r.done_res = done;
        r.read_data = rx_byte;
        r.request_dropped = dropped;
        return r;
    endfunction

    // Beat of the given kind with random operands
    function automatic i2cm_pkg::t_in_beat rand_beat(logic [1:0] kind);
        i2cm_pkg::t_in_beat b;
        b.kind = kind;
        b.device_address = 8'($urandom);
        b.register_address = 8'($urandom);
        b.write_data = 8'($urandom);
        b.sda_in = 1'($urandom_range(0, 1));
        return b;
    endfunction

    // Noise beat: requests only while busy, so a transaction is never started by it
    function automatic i2cm_pkg::t_in_beat stray_beat(bit busy);
        int unsigned pick;
        pick = $urandom_range(0, 2);
        if (!busy) return rand_beat(pick == 0 ? KIND_NONE : i2cm_pkg::KIND_TICK);
        case (pick)
            0: return rand_beat(i2cm_pkg::KIND_WRITE);
            1: return rand_beat(i2cm_pkg::KIND_READ);
            default: return rand_beat(KIND_NONE);
        endcase
    endfunction

    task automatic add_row(input logic [1:0] kind, input logic [7:0] dev, input logic [7:0] rega,
                           input logic [7:0] data, input logic sda, input int unsigned reps,
                           input bit typed, input i2cm_pkg::t_out_beat res);
        t_script_row row;
        row.beat = {kind, dev, rega, data, sda};
        row.reps = reps;
        row.typed = typed;
        row.res = res;
        script.push_back(row);
    endtask

    // Send one request beat; on acceptance, queue the predicted (or given) result
    task automatic push_beat(input i2cm_pkg::t_in_beat b, input bit typed,
                             input i2cm_pkg::t_out_beat typed_res);
        i2cm_pkg::t_out_beat predicted;
        if (!calm) begin
            while ($urandom_range(0, 99) < 29) begin
                in_ch.valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        in_ch.valid <= 1'b1;
        in_ch.kind <= b.kind;
        in_ch.device_address <= b.device_address;
        in_ch.register_address <= b.register_address;
        in_ch.write_data <= b.write_data;
        in_ch.sda_in <= b.sda_in;
        do @(posedge i_clk); while (!in_ch.ready);
        predicted = bus_half_step(b);
        pending_res.push_back(typed ? typed_res : predicted);
    endtask

    // Hold off the sender until every pending result has come back
    task automatic drain_results();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_res.size() != 0) @(posedge i_clk);
    endtask

    task automatic check_field(input string fld, input logic [7:0] want, input logic [7:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0h got %0h", $time, fld, want, got);
            fails++;
        end
    endtask

    // Result monitor and receiver stalls
    always @(posedge i_clk) begin : res_mon
        i2cm_pkg::t_out_beat want;
        if (res_ch.valid && res_ch.ready) begin
            if (pending_res.size() == 0) begin
                $display("%0t: result beat with nothing pending", $time);
                fails++;
            end else begin
                want = pending_res.pop_front();
                check_field("scl", 8'(want.scl), 8'(res_ch.scl));
                check_field("sda_out", 8'(want.sda_out), 8'(res_ch.sda_out));
                check_field("busy_res", 8'(want.busy_res), 8'(res_ch.busy_res));
                check_field("done_res", 8'(want.done_res), 8'(res_ch.done_res));
                check_field("read_data", want.read_data, res_ch.read_data);
                check_field("request_dropped", 8'(want.request_dropped),
                            8'(res_ch.request_dropped));
            end
        end
        res_ch.ready <= calm || ($urandom_range(0, 99) >= 29);
    end

    // Run watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin : stim
        i2cm_pkg::t_in_beat req;
        t_script_row row;
        int unsigned n;
        int unsigned txn_len;

        i_rst_n <= 1'b0;
        in_ch.valid <= 1'b0;
        in_ch.kind <= KIND_NONE;
        in_ch.device_address <= '0;
        in_ch.register_address <= '0;
        in_ch.write_data <= '0;
        in_ch.sda_in <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed script; result fields: scl, sda, busy, done, read_data, dropped
        // idle tick and the unused kind leave the lines released
        add_row(i2cm_pkg::KIND_TICK,  8'h00, 8'h00, 8'h00, 1'b0, 1, 1'b1,
                {1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0});
        add_row(KIND_NONE,            8'hFF, 8'hFF, 8'hFF, 1'b1, 1, 1'b1,
                {1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0});
        // write: lines do not move until the first tick
        add_row(i2cm_pkg::KIND_WRITE, 8'hFF, 8'h00, 8'hA5, 1'b0, 1, 1'b1,
                {1'b1, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0});
        // request while busy is dropped
        add_row(i2cm_pkg::KIND_READ,  8'h00, 8'hFF, 8'h00, 1'b0, 1, 1'b1,
                {1'b1, 1'b1, 1'b1, 1'b0, 8'h00, 1'b1});
        add_row(i2cm_pkg::KIND_TICK,  8'h00, 8'h00, 8'h00, 1'b1, 1, 1'b1,
                {1'b1, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0});
        // start condition: SDA low with SCL high
        add_row(i2cm_pkg::KIND_TICK,  8'h00, 8'h00, 8'h00, 1'b1, 1, 1'b1,
                {1'b1, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0});
        add_row(i2cm_pkg::KIND_WRITE, 8'h12, 8'h34, 8'h56, 1'b0, 1, 1'b1,
                {1'b1, 1'b0, 1'b1, 1'b0, 8'h00, 1'b1});
        add_row(i2cm_pkg::KIND_TICK,  8'h00, 8'h00, 8'h00, 1'b0, WRITE_TICKS - 3, 1'b0, '0);
        add_row(i2cm_pkg::KIND_TICK,  8'h00, 8'h00, 8'h00, 1'b0, 1, 1'b1,
                {1'b1, 1'b1, 1'b0, 1'b1, 8'h00, 1'b0});
        // read with SDA held high captures all ones
        add_row(i2cm_pkg::KIND_READ,  8'h00, 8'hFF, 8'h00, 1'b1, 1, 1'b1,
                {1'b1, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0});
        add_row(i2cm_pkg::KIND_TICK,  8'h00, 8'h00, 8'h00, 1'b1, READ_TICKS - 1, 1'b0, '0);
        add_row(i2cm_pkg::KIND_TICK,  8'h00, 8'h00, 8'h00, 1'b1, 1, 1'b1,
                {1'b1, 1'b1, 1'b0, 1'b1, 8'hFF, 1'b0});
        // write of the opposite extremes, unused kind while busy
        add_row(i2cm_pkg::KIND_WRITE, 8'h00, 8'hFF, 8'h00, 1'b0, 1, 1'b1,
                {1'b1, 1'b1, 1'b1, 1'b0, 8'hFF, 1'b0});
        add_row(KIND_NONE,            8'h00, 8'h00, 8'h00, 1'b0, 1, 1'b1,
                {1'b1, 1'b1, 1'b1, 1'b0, 8'hFF, 1'b0});
        add_row(i2cm_pkg::KIND_TICK,  8'h00, 8'h00, 8'h00, 1'b0, WRITE_TICKS, 1'b0, '0);
        // read with SDA held low captures all zeros
        add_row(i2cm_pkg::KIND_READ,  8'hFE, 8'h5A, 8'hFF, 1'b0, 1, 1'b0, '0);
        add_row(i2cm_pkg::KIND_TICK,  8'hFF, 8'hFF, 8'hFF, 1'b0, READ_TICKS - 1, 1'b0, '0);
        add_row(i2cm_pkg::KIND_TICK,  8'h00, 8'h00, 8'h00, 1'b0, 1, 1'b1,
                {1'b1, 1'b1, 1'b0, 1'b1, 8'h00, 1'b0});
        add_row(KIND_NONE,            8'h00, 8'h00, 8'h00, 1'b0, 1, 1'b1,
                {1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0});

        foreach (script[i]) begin
            row = script[i];
            for (int k = 0; k < row.reps; k++) push_beat(row.beat, row.typed, row.res);
        end
        drain_results();

        // Random transactions with random content, noise between and inside them
        n = 0;
        while (n < RANDOM_ITEMS) begin
            calm = (n >= 100 && n < 200);
            if ($urandom_range(0, 99) < 85) begin
                req = rand_beat($urandom_range(0, 1) ? i2cm_pkg::KIND_READ
                                                     : i2cm_pkg::KIND_WRITE);
                push_beat(req, 1'b0, '0);
                n++;
                txn_len = (req.kind == i2cm_pkg::KIND_READ) ? READ_TICKS : WRITE_TICKS;
                for (int t = 0; t < txn_len; t++) begin
                    if ($urandom_range(0, 99) < 5) push_beat(stray_beat(1'b1), 1'b0, '0);
                    push_beat(rand_beat(i2cm_pkg::KIND_TICK), 1'b0, '0);
                    n++;
                end
                if ($urandom_range(0, 3) == 0) drain_results();
            end else begin
                push_beat(stray_beat(1'b0), 1'b0, '0);
            end
        end
        calm = 1'b0;
        drain_results();
        repeat (8) @(posedge i_clk);

        if (fails == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/i2cm_pkg.sv
rtl/i2cm_if.sv
rtl/i2c_register_access_master_core.sv
test/i2c_register_access_master_core_tb.sv
